// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, checks the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/cfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the colon header fragment parser modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Largest legal size field; the 11-bit data_size field is sized for it
  localparam int MAX_DATA_BYTES = 1024;

  // Result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } cfp_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] total_frags;
    logic [15:0] frag_number;
    logic [10:0] data_size;
    logic        last;
  } cfp_out_t;

  // Input register toward the parser
  typedef struct packed {
    logic    vld;
    cfp_in_t word;
  } cfp_stage_t;

  // Parser result toward the output register
  typedef struct packed {
    logic     vld;
    cfp_out_t word;
  } cfp_res_t;

endpackage
`default_nettype wire

// File: hdl/cfp_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_in_reg
// Input register: holds one word until the parser takes it.
// ----------------------------------------------------------------------------
module cfp_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  cfp_pkg::cfp_in_t    in_word_i,
  output logic                in_stall_o,
  input  wire                 advance_i,
  output cfp_pkg::cfp_stage_t stage_o
);
  import cfp_pkg::*;

  logic    vld_q, vld_d;
  cfp_in_t word_q;
  logic    load;

  assign in_stall_o = vld_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.word = word_q;

endmodule
`default_nettype wire

// File: hdl/cfp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_parse
// Parser state machine: field accumulators, byte position and data count.
// ----------------------------------------------------------------------------
module cfp_parse #(
  parameter int MAX_MSG_BYTES = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cfp_pkg::cfp_stage_t stage_i,
  input  wire                 advance_i,
  output cfp_pkg::cfp_res_t   res_o
);
  import cfp_pkg::*;

  localparam int PW = $clog2(MAX_MSG_BYTES + 1);
  localparam int SW = $clog2(MAX_DATA_BYTES + 2);
  localparam logic [PW-1:0] POS_MAX   = PW'(MAX_MSG_BYTES);
  localparam logic [SW-1:0] SIZE_MAX  = SW'(MAX_DATA_BYTES);
  localparam logic [SW-1:0] SIZE_CAP  = SW'(MAX_DATA_BYTES + 1);
  localparam logic [15:0]   NUM_CAP   = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_TOTAL = 3'd0,
    PH_FRAG  = 3'd1,
    PH_SIZE  = 3'd2,
    PH_NAME  = 3'd3,
    PH_DATA  = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  phase_e        phase_q, phase_d, phase_s;
  logic          digits_q, digits_d, digits_s;
  logic [15:0]   total_q, total_d, total_s;
  logic [15:0]   frag_q, frag_d, frag_s;
  logic [SW-1:0] size_q, size_d, size_s;
  logic [SW-1:0] left_q, left_d, left_s, left_dec;
  logic [PW-1:0] pos_q, pos_d, pos_s;

  logic [7:0]    b;
  logic          is_colon, is_digit;
  logic [3:0]    digit;
  logic [19:0]   num_src, num_x10;
  logic [15:0]   num_sat;
  logic [SW+3:0] size_x10;
  logic [SW-1:0] size_sat;
  cfp_res_t      res;

  assign b        = stage_i.word.in_byte;
  assign is_colon = (b == COLON_CHAR);
  assign is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
  assign digit    = b[3:0];

  always_comb begin
    // Start values: a first byte restarts the parser
    phase_s  = phase_q;
    digits_s = digits_q;
    total_s  = total_q;
    frag_s   = frag_q;
    size_s   = size_q;
    left_s   = left_q;
    pos_s    = pos_q;
    if (stage_i.word.first_byte) begin
      phase_s  = PH_TOTAL;
      digits_s = 1'b0;
      total_s  = '0;
      frag_s   = '0;
      size_s   = '0;
      left_s   = '0;
      pos_s    = '0;
    end
  end

  // acc * 10 + digit, saturating; one shared path for the two 16-bit fields
  always_comb begin
    num_src  = (phase_s == PH_TOTAL) ? {4'd0, total_s} : {4'd0, frag_s};
    num_x10  = (num_src << 3) + (num_src << 1) + {16'd0, digit};
    num_sat  = (num_x10 > {4'd0, NUM_CAP}) ? NUM_CAP : num_x10[15:0];
    size_x10 = ({4'd0, size_s} << 3) + ({4'd0, size_s} << 1) + (SW+4)'(digit);
    size_sat = (size_x10 > {4'd0, SIZE_CAP}) ? SIZE_CAP : size_x10[SW-1:0];
    left_dec = (left_s != '0) ? left_s - 1'b1 : '0;
  end

  always_comb begin
    phase_d  = phase_s;
    digits_d = digits_s;
    total_d  = total_s;
    frag_d   = frag_s;
    size_d   = size_s;
    left_d   = left_s;
    pos_d    = pos_s;
    res      = '0;

    if (phase_s != PH_DONE) begin
      if (pos_s != POS_MAX) begin
        pos_d = pos_s + 1'b1;
      end
    end

    if (phase_s != PH_DONE && pos_s == POS_MAX) begin
      // message bound reached before completion
      phase_d       = PH_DONE;
      res.vld       = 1'b1;
      res.word.kind = KIND_ERR;
      res.word.last = 1'b1;
    end else begin
      unique case (phase_s) inside
        PH_TOTAL, PH_FRAG, PH_SIZE: begin
          if (is_colon) begin
            if (phase_s == PH_SIZE && size_s > SIZE_MAX) begin
              phase_d       = PH_DONE;
              res.vld       = 1'b1;
              res.word.kind = KIND_ERR;
              res.word.last = 1'b1;
            end else begin
              phase_d  = (phase_s == PH_TOTAL) ? PH_FRAG :
                         (phase_s == PH_FRAG)  ? PH_SIZE : PH_NAME;
              digits_d = 1'b0;
            end
          end else if (is_digit && !digits_s) begin
            if (phase_s == PH_TOTAL) begin
              total_d = num_sat;
            end else if (phase_s == PH_FRAG) begin
              frag_d = num_sat;
            end else begin
              size_d = size_sat;
            end
          end else begin
            digits_d = 1'b1;
          end
        end
        PH_NAME: begin
          res.vld = 1'b1;
          if (is_colon) begin
            res.word.kind        = KIND_HDR;
            res.word.total_frags = total_s;
            res.word.frag_number = frag_s;
            res.word.data_size   = 11'(size_s);
            res.word.last        = (size_s == '0);
            if (size_s == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_DATA;
              left_d  = size_s;
            end
          end else begin
            res.word.kind     = KIND_NAME;
            res.word.out_byte = b;
          end
        end
        PH_DATA: begin
          left_d            = left_dec;
          res.vld           = 1'b1;
          res.word.kind     = KIND_DATA;
          res.word.out_byte = b;
          if (left_dec == '0) begin
            phase_d       = PH_DONE;
            res.word.last = 1'b1;
          end
        end
        default: begin
          // done: bytes are dropped until the next first byte
        end
      endcase
    end

    res.vld = res.vld && stage_i.vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOTAL;
      digits_q <= 1'b0;
      total_q  <= '0;
      frag_q   <= '0;
      size_q   <= '0;
      left_q   <= '0;
      pos_q    <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      total_q  <= total_d;
      frag_q   <= frag_d;
      size_q   <= size_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

// File: hdl/colon_header_fragment_parser_unit.sv
`default_nettype none
// Throughput: one word per cycle while the receiver does not stall the output register.
// One parser pass per byte (multiply by ten, compare); results are held in the output register.
// Bytes that produce no result (numeric fields, colons, dropped bytes) leave no output word.
// Reset: rst_ni asynchronous, active low; clears both valid bits and the parser state.
// ----------------------------------------------------------------------------
// colon_header_fragment_parser_unit
// Parses total:frag:size:filename:data messages byte by byte and emits
// filename bytes, a header word, data bytes and format errors.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module colon_header_fragment_parser_unit #(
  parameter int MAX_MSG_BYTES  = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  cfp_pkg::cfp_in_t  in_word_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output cfp_pkg::cfp_out_t out_word_o
);
  import cfp_pkg::*;

  cfp_stage_t stage;
  cfp_res_t   res;
  logic       advance;
  logic       out_vld_q, out_vld_d;
  cfp_out_t   out_q;
  logic       out_load;

  // The parser takes the held word whenever the output register is free
  // or is being emptied this cycle; a word without a result still advances.
  assign advance  = stage.vld && (!out_vld_q || !out_stall_i);
  assign out_load = advance && res.vld;

  cfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  cfp_parse #(
    .MAX_MSG_BYTES  (MAX_MSG_BYTES)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .res_o     (res)
  );

  // Output register: holds a result until the receiver takes it
  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res.word;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Input side only stalls while a word is held that cannot move on
  `ASSERT_IMPL(a_stall_needs_word, in_stall_o, stage.vld && out_vld_q && out_stall_i,
    "input stalled without a blocked word")
  // A result produced by the parser shows up at the output the next cycle
  `ASSERT_CLK(a_result_lands, out_load |=> out_valid_o,
    "parser result not presented")
  // Error words carry only the last flag
  `ASSERT_IMPL(a_error_word, out_valid_o && out_word_o.kind == KIND_ERR,
    out_word_o.last && out_word_o.out_byte == '0 && out_word_o.data_size == '0,
    "malformed error word")

endmodule
`default_nettype wire

// File: tb/colon_header_fragment_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds total:frag:size:filename:data messages into the fragment parser one
// byte per word and scores every output word against a typed-in word or an in-bench parser.
// A short directed table runs first, then random messages under three
// sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import cfp_pkg::*;

  localparam int MSG_BOUND   = 1024;            // bytes per message before a bound error
  localparam int DATA_CAP    = MAX_DATA_BYTES;  // largest legal size field
  localparam int NUM_CAP     = 65535;           // saturation point of the count fields
  localparam int PHASE_BYTES = 200;             // bytes sent per stall mix
  localparam int QUIET_LIMIT = 2000;            // cycles with no handshake before giving up

  // Parser position inside one message
  typedef enum logic [2:0] {
    PH_TOTAL, PH_FRAG, PH_SIZE, PH_NAME, PH_DATA, PH_DONE
  } parse_phase_e;

  // How a directed row is scored
  typedef enum logic [1:0] {
    CHK_NONE,   // typed in: no output word
    CHK_WORD,   // typed in: exactly this output word
    CHK_MODEL   // expectation comes from the in-bench parser
  } check_e;

  typedef struct packed {
    cfp_in_t  word;
    check_e   chk;
    cfp_out_t want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  cfp_in_t  in_word_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  cfp_out_t out_word_o;

  colon_header_fragment_parser_unit #(
    .MAX_MSG_BYTES (MSG_BOUND)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int send_idle_pct = 10;
  int recv_idle_pct = 82;

  cfp_out_t   fragment_results_q[$];  // output words still owed by the DUT
  dir_row_t   directed_rows[$];
  logic [7:0] msg_q[$];               // message under construction

  int mismatch_cnt    = 0;
  int results_checked = 0;
  int bytes_sent      = 0;
  int live_bytes      = 0;            // bytes the parser actually looked at
  int quiet_cycles    = 0;
  int kind_cnt [4];

  // In-bench copy of the parser state, at the block's widths
  parse_phase_e phase_q;
  logic         digits_done;
  logic [15:0]  total_acc;
  logic [15:0]  frag_acc;
  logic [10:0]  size_acc;
  logic [10:0]  data_left;
  logic [10:0]  byte_pos;

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------
  function automatic void clear_parse_state();
    phase_q     = PH_TOTAL;
    digits_done = 1'b0;
    total_acc   = '0;
    frag_acc    = '0;
    size_acc    = '0;
    data_left   = '0;
    byte_pos    = '0;
  endfunction

  // atoi step, clamped at cap
  function automatic int unsigned sat_decimal(int unsigned acc, int unsigned digit,
                                              int unsigned cap);
    int unsigned v;
    if (acc > cap) acc = cap;
    v = acc * 10 + digit;
    return (v > cap) ? cap : v;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a word.
  function automatic bit parse_fragment_byte(input cfp_in_t w, output cfp_out_t res);
    int unsigned pos;
    int unsigned digit;
    bit          fail;
    res  = '0;
    fail = 1'b0;
    if (w.first_byte) clear_parse_state();
    if (phase_q == PH_DONE) return 1'b0;
    live_bytes++;

    pos = byte_pos;
    if (byte_pos < MSG_BOUND) byte_pos++;
    if (pos >= MSG_BOUND) begin
      fail = 1'b1;
    end else if (phase_q <= PH_SIZE) begin
      if (w.in_byte == COLON_CHAR) begin
        // size is checked only when its field closes
        if (phase_q == PH_SIZE && size_acc > DATA_CAP) begin
          fail = 1'b1;
        end else begin
          phase_q     = parse_phase_e'(phase_q + 3'd1);
          digits_done = 1'b0;
          return 1'b0;
        end
      end else begin
        if (w.in_byte >= DIGIT_LO && w.in_byte <= DIGIT_HI && !digits_done) begin
          digit = w.in_byte - DIGIT_LO;
          case (phase_q)
            PH_TOTAL: total_acc = 16'(sat_decimal(total_acc, digit, NUM_CAP));
            PH_FRAG:  frag_acc  = 16'(sat_decimal(frag_acc, digit, NUM_CAP));
            default:  size_acc  = 11'(sat_decimal(size_acc, digit, DATA_CAP + 1));
          endcase
        end else begin
          digits_done = 1'b1;
        end
        return 1'b0;
      end
    end

    if (fail) begin
      phase_q  = PH_DONE;
      res.kind = KIND_ERR;
      res.last = 1'b1;
      return 1'b1;
    end

    if (phase_q == PH_NAME) begin
      if (w.in_byte == COLON_CHAR) begin
        res.kind        = KIND_HDR;
        res.total_frags = total_acc;
        res.frag_number = frag_acc;
        res.data_size   = size_acc;
        res.last        = (size_acc == 0);
        if (size_acc == 0) begin
          phase_q = PH_DONE;
        end else begin
          phase_q   = PH_DATA;
          data_left = size_acc;
        end
      end else begin
        res.kind     = KIND_NAME;
        res.out_byte = w.in_byte;
      end
      return 1'b1;
    end

    // data bytes: colons are plain payload here
    if (data_left > 0) data_left--;
    res.kind     = KIND_DATA;
    res.out_byte = w.in_byte;
    if (data_left == 0) begin
      phase_q  = PH_DONE;
      res.last = 1'b1;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_row(logic [7:0] b, logic first, check_e chk,
                                  logic [1:0] kind, logic [7:0] ob, int unsigned t,
                                  int unsigned f, int unsigned s, logic last);
    dir_row_t r;
    r.word.in_byte       = b;
    r.word.first_byte    = first;
    r.chk                = chk;
    r.want.kind          = kind;
    r.want.out_byte      = ob;
    r.want.total_frags   = 16'(t);
    r.want.frag_number   = 16'(f);
    r.want.data_size     = 11'(s);
    r.want.last          = last;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == COLON_CHAR);
    return b;
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == COLON_CHAR || (b >= DIGIT_LO && b <= DIGIT_HI));
    return b;
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(2))
      0:       return COLON_CHAR;
      1:       return DIGIT_LO + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  // Decimal field: sometimes empty (when zero), sometimes a leading zero,
  // sometimes trailing junk that the parser must skip.
  function automatic void push_field(int unsigned v);
    if (!(v == 0 && $urandom_range(1) == 0)) begin
      if ($urandom_range(7) == 0) msg_q.push_back(DIGIT_LO);
      push_text($sformatf("%0d", v));
    end
    if ($urandom_range(5) == 0) begin
      msg_q.push_back(pick_junk());
      if ($urandom_range(1) == 0) msg_q.push_back(DIGIT_LO + 8'($urandom_range(9)));
    end
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(9)) inside
      0:          return 0;
      1, 2, 3, 4: return $urandom_range(99);
      5, 6, 7:    return $urandom_range(NUM_CAP);
      8:          return $urandom_range(NUM_CAP + 5, NUM_CAP - 5);   // around saturation
      default:    return $urandom_range(99999999, 100000);
    endcase
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(9)) inside
      0, 1:    return 0;
      8:       return $urandom_range(64, 13);
      default: return $urandom_range(12, 1);
    endcase
  endfunction

  function automatic void build_message(int unsigned size);
    msg_q.delete();
    push_field(pick_count());
    msg_q.push_back(COLON_CHAR);
    push_field(pick_count());
    msg_q.push_back(COLON_CHAR);
    push_field(size);
    msg_q.push_back(COLON_CHAR);
    repeat ($urandom_range(5)) msg_q.push_back(pick_plain());
    msg_q.push_back(COLON_CHAR);
    repeat (size) msg_q.push_back(($urandom_range(3) == 0) ? COLON_CHAR
                                                            : 8'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one word per call, random idle cycles ahead of it. Entered and
  // left at a falling edge; the word's prediction is queued on acceptance.
  // --------------------------------------------------------------------------
  task automatic send_word(input cfp_in_t w, input check_e chk, input cfp_out_t want);
    cfp_out_t res;
    bit       has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    has_res = parse_fragment_byte(w, res);
    case (chk)
      CHK_WORD:  fragment_results_q.push_back(want);
      CHK_MODEL: if (has_res) fragment_results_q.push_back(res);
      default:   ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_message();
    cfp_in_t w;
    for (int i = 0; i < msg_q.size(); i++) begin
      w.in_byte    = msg_q[i];
      w.first_byte = (i == 0);
      send_word(w, CHK_MODEL, '0);
    end
  endtask

  // Hold the sender off until every owed word has come back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (fragment_results_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall and output scoring
  // --------------------------------------------------------------------------
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    cfp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      kind_cnt[out_word_o.kind]++;
      if (fragment_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected word kind=%0d byte=%02h tot=%0d frag=%0d size=%0d last=%0d",
                   $realtime, out_word_o.kind, out_word_o.out_byte, out_word_o.total_frags,
                   out_word_o.frag_number, out_word_o.data_size, out_word_o.last);
      end else begin
        want = fragment_results_q.pop_front();
        if (out_word_o.kind !== want.kind || out_word_o.out_byte !== want.out_byte ||
            out_word_o.total_frags !== want.total_frags ||
            out_word_o.frag_number !== want.frag_number ||
            out_word_o.data_size !== want.data_size || out_word_o.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: want kind=%0d byte=%02h tot=%0d frag=%0d size=%0d last=%0d",
                     $realtime, want.kind, want.out_byte, want.total_frags,
                     want.frag_number, want.data_size, want.last);
            $display("%0t:  got kind=%0d byte=%02h tot=%0d frag=%0d size=%0d last=%0d",
                     $realtime, out_word_o.kind, out_word_o.out_byte, out_word_o.total_frags,
                     out_word_o.frag_number, out_word_o.data_size, out_word_o.last);
          end
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("colon_header_fragment_parser_unit: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_goal;
    int unsigned keep;
    int          r;
    cfp_in_t     w;

    foreach (kind_cnt[k]) kind_cnt[k] = 0;
    clear_parse_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    // No leading first_byte: parser is already in the total field after reset.
    // Empty fragment field, zero and all-ones filename bytes, colon as data.
    add_row("3",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row("2",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(8'h00,      1'b0, CHK_WORD,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(8'hFF,      1'b0, CHK_WORD,  KIND_NAME, 8'hFF, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_WORD,  KIND_HDR,  8'h00, 3, 0, 2, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_MODEL, KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(8'hFF,      1'b0, CHK_WORD,  KIND_DATA, 8'hFF, 0, 0, 0, 1'b1);
    add_row("x",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);  // after completion
    // Size field 9999 clamps above the data cap: error on its closing colon.
    add_row(COLON_CHAR, 1'b1, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row("9",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row("9",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row("9",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row("9",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_WORD,  KIND_ERR,  8'h00, 0, 0, 0, 1'b1);
    add_row("7",        1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);  // after error
    // Zero byte in a numeric field is a non-digit; zero size closes on the header.
    add_row(8'h00,      1'b1, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_NONE,  KIND_NAME, 8'h00, 0, 0, 0, 1'b0);
    add_row(COLON_CHAR, 1'b0, CHK_WORD,  KIND_HDR,  8'h00, 0, 0, 0, 1'b1);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].chk, directed_rows[i].want);
    wait_results_drained();

    // Random messages under three stall mixes: sender light / receiver heavy,
    // the reverse, then no idling at all.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin send_idle_pct = 10; recv_idle_pct = 82; end
        1:       begin send_idle_pct = 82; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      phase_goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_goal) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // well formed, sometimes with ignored bytes past its end
          build_message(pick_size());
          if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) msg_q.push_back(pick_noise());
          send_message();
        end else if (r < 80) begin
          // size above the cap
          msg_q.delete();
          push_field(pick_count());
          msg_q.push_back(COLON_CHAR);
          push_field(pick_count());
          msg_q.push_back(COLON_CHAR);
          case ($urandom_range(2))
            0:       push_field(DATA_CAP + 1);
            1:       push_field($urandom_range(9999, DATA_CAP + 2));
            default: push_field($urandom_range(99999999, 10000));
          endcase
          msg_q.push_back(COLON_CHAR);
          repeat (2) msg_q.push_back(pick_plain());
          send_message();
        end else if (r < 90) begin
          // cut short; the next message restarts the parser
          build_message(pick_size());
          keep = $urandom_range(msg_q.size() - 1, 1);
          while (msg_q.size() > keep) msg_q.delete(msg_q.size() - 1);
          send_message();
        end else begin
          // loose bytes with scattered first flags
          repeat ($urandom_range(8, 1)) begin
            w.in_byte    = pick_noise();
            w.first_byte = ($urandom_range(3) == 0);
            send_word(w, CHK_MODEL, '0);
          end
        end
        if ($urandom_range(9) == 0) wait_results_drained();
      end
      wait_results_drained();
    end

    repeat (4) @(posedge clk_i);
    if (fragment_results_q.size() != 0) mismatch_cnt++;

    $display("Sent %0d bytes (%0d parsed), checked %0d words: %0d name, %0d header,",
             bytes_sent, live_bytes, results_checked, kind_cnt[KIND_NAME], kind_cnt[KIND_HDR]);
    $display("  %0d data, %0d error; directed table and three stall mixes; %0d bad.",
             kind_cnt[KIND_DATA], kind_cnt[KIND_ERR], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("colon_header_fragment_parser_unit: match");
    end else begin
      $display("colon_header_fragment_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/cfp_pkg.sv
hdl/cfp_in_reg.sv
hdl/cfp_parse.sv
hdl/colon_header_fragment_parser_unit.sv
tb/colon_header_fragment_parser_unit_tb.sv
